[rtl/bgs_pkg.sv]
// Shared types, constants and register codes for the battery gauge smoother.
package bgs_pkg;

    localparam int ADC_WIDTH   = 10;
    localparam int BREAKPOINTS = 11;
    localparam int BP_W        = 10;
    localparam int CMP_W       = (ADC_WIDTH > BP_W) ? ADC_WIDTH : BP_W;
    localparam int IDX_W       = $clog2(BREAKPOINTS);
    localparam int CAP_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 11;
    localparam int HOLD_W      = 8;
    localparam int LOW_W       = 60;
    localparam int HIGH_W      = 50;
    localparam int TABLE_W     = LOW_W + HIGH_W;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 60;

    // Stream beat layouts, whole bytes.
    localparam int IN_BITS     = ADC_WIDTH + 2;
    localparam int S_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = CAP_W + STATUS_W + 1;
    localparam int M_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // Shared divider: numerator covers (sample - bp) * 10 and hold * 6.
    localparam int DIV_NUM_W   = BP_W + 4;
    localparam int DIV_DEN_W   = BP_W;
    localparam int DIV_CNT_W   = $clog2(DIV_NUM_W);

    localparam logic [CAP_W-1:0]    CAP_UNMEASURED = CAP_W'(120);
    localparam logic [CAP_W-1:0]    CAP_FULL       = CAP_W'(100);
    localparam logic [CAP_W-1:0]    CAP_EMPTY      = CAP_W'(0);
    localparam logic signed [7:0]   DIFF_LIMIT     = 8'sd5;
    localparam logic signed [7:0]   RATE_BASE      = 8'sd6;
    localparam logic [IDX_W-1:0]    IDX_FIRST      = IDX_W'(1);
    localparam logic [IDX_W-1:0]    IDX_LAST       = IDX_W'(BREAKPOINTS - 1);

    localparam logic [STATUS_W-1:0] STATUS_CHARGING     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_CHARGING = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNKNOWN      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE_HOLD = 3'd5;

    localparam logic [LOW_W-1:0]  RST_CHARGE_LOW     = 60'd581523436923736514;
    localparam logic [HIGH_W-1:0] RST_CHARGE_HIGH    = 50'd643817244484108;
    localparam logic [LOW_W-1:0]  RST_DISCHARGE_LOW  = 60'd547713422125881764;
    localparam logic [HIGH_W-1:0] RST_DISCHARGE_HIGH = 50'd610799651908078;
    localparam logic [HOLD_W-1:0] RST_CHARGE_HOLD    = 8'd48;
    localparam logic [HOLD_W-1:0] RST_DISCHARGE_HOLD = 8'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SEARCH,
        ST_DIV_RAW,
        ST_SHOW,
        ST_HOLD,
        ST_DIV_HOLD,
        ST_REPORT
    } bgs_state_t;

    typedef struct packed {
        logic load_in;
        logic dec_count;
        logic raw_full;
        logic raw_zero;
        logic search_init;
        logic search_step;
        logic div_start_raw;
        logic raw_from_div;
        logic update_shown;
        logic div_start_hold;
        logic count_from_div;
        logic report;
    } bgs_cmd_t;

    typedef struct packed {
        logic sample_zero;
        logic count_zero;
        logic full;
        logic le_first;
        logic le_cur;
        logic idx_last;
        logic div_busy;
        logic out_free;
    } bgs_stat_t;

endpackage

[rtl/bgs_divider.sv]
// Restoring divider, one quotient bit per cycle.
module bgs_divider
    import bgs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] dividend,
    input  logic [DIV_DEN_W-1:0] divisor,
    output logic                 busy,
    output logic [DIV_NUM_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   partial;
    logic [DIV_DEN_W:0]   trial;

    assign partial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign trial   = partial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_NUM_W - 1);
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            // The numerator register fills with quotient bits from the bottom.
            if (partial >= {1'b0, den_reg}) begin
                rem_next = trial[DIV_DEN_W-1:0];
                num_next = {num_reg[DIV_NUM_W-2:0], 1'b1};
            end else begin
                rem_next = partial[DIV_DEN_W-1:0];
                num_next = {num_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = num_reg;

endmodule

[rtl/bgs_datapath.sv]
// Datapath: configuration, breakpoint search, pacing state and result register.
module bgs_datapath
    import bgs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_TDATA_W-1:0]  s_tdata,      // [9:0] adc_sample, [10] adapter_present, [11] charge_full
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,      // [6:0] shown_capacity, [8:7] supply_status, [9] status_changed
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  bgs_cmd_t              cmd,
    output bgs_stat_t             stat
);

    // Configuration registers.
    logic [LOW_W-1:0]  chg_low_reg, dis_low_reg;
    logic [HIGH_W-1:0] chg_high_reg, dis_high_reg;
    logic [HOLD_W-1:0] chg_hold_reg, dis_hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chg_low_reg  <= RST_CHARGE_LOW;
            chg_high_reg <= RST_CHARGE_HIGH;
            dis_low_reg  <= RST_DISCHARGE_LOW;
            dis_high_reg <= RST_DISCHARGE_HIGH;
            chg_hold_reg <= RST_CHARGE_HOLD;
            dis_hold_reg <= RST_DISCHARGE_HOLD;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CHARGE_LOW:     chg_low_reg  <= cfg_data[LOW_W-1:0];
                CFG_CHARGE_HIGH:    chg_high_reg <= cfg_data[HIGH_W-1:0];
                CFG_DISCHARGE_LOW:  dis_low_reg  <= cfg_data[LOW_W-1:0];
                CFG_DISCHARGE_HIGH: dis_high_reg <= cfg_data[HIGH_W-1:0];
                CFG_CHARGE_HOLD:    chg_hold_reg <= cfg_data[HOLD_W-1:0];
                CFG_DISCHARGE_HOLD: dis_hold_reg <= cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Input beat and working registers.
    logic [ADC_WIDTH-1:0] sample_reg;
    logic                 ac_reg, full_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [CAP_W-1:0]     raw_reg;
    logic [CAP_W-1:0]     shown_reg, shown_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [STATUS_W-1:0]  last_status_reg;
    logic [CAP_W-1:0]     last_cap_reg;
    logic                 out_valid_reg;
    logic [OUT_BITS-1:0]  out_data_reg;

    logic [TABLE_W-1:0]   table_bits;
    logic [BP_W-1:0]      bp_first, bp_cur, bp_prev;
    logic [CMP_W-1:0]     sample_ext;
    logic [CMP_W-1:0]     span_v;
    logic [BP_W-1:0]      span_vb, span_ba;
    logic [DIV_NUM_W-1:0] num_raw, num_hold, div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_q;
    logic                 div_busy;
    logic [CAP_W-1:0]     tens;
    logic signed [7:0]    diff, diff_clamped, rate_div;
    logic [HOLD_W-1:0]    hold_base;
    logic [COUNT_W-1:0]   hold_six;
    logic [STATUS_W-1:0]  status_now;
    logic                 changed_now;

    assign table_bits = ac_reg ? {chg_high_reg, chg_low_reg} : {dis_high_reg, dis_low_reg};
    assign bp_first   = table_bits[BP_W-1:0];
    assign bp_cur     = table_bits[idx_reg * BP_W +: BP_W];
    assign bp_prev    = table_bits[(idx_reg - IDX_W'(1)) * BP_W +: BP_W];
    assign sample_ext = CMP_W'(sample_reg);

    // The search guarantees bp_prev < sample <= bp_cur, so both spans fit a breakpoint.
    assign span_v  = sample_ext - CMP_W'(bp_prev);
    assign span_vb = span_v[BP_W-1:0];
    assign span_ba = bp_cur - bp_prev;
    assign num_raw = (DIV_NUM_W'(span_vb) << 3) + (DIV_NUM_W'(span_vb) << 1);

    // Reload period: hold * 6 / (6 +- clamped difference).
    assign diff = signed'({1'b0, raw_reg}) - signed'({1'b0, shown_reg});
    always_comb begin
        if (ac_reg) begin
            diff_clamped = (diff < -DIFF_LIMIT) ? -DIFF_LIMIT : diff;
            rate_div     = RATE_BASE + diff_clamped;
            hold_base    = chg_hold_reg;
        end else begin
            diff_clamped = (diff > DIFF_LIMIT) ? DIFF_LIMIT : diff;
            rate_div     = RATE_BASE - diff_clamped;
            hold_base    = dis_hold_reg;
        end
    end
    assign hold_six = (COUNT_W'(hold_base) << 2) + (COUNT_W'(hold_base) << 1);
    assign num_hold = DIV_NUM_W'(hold_six);

    assign div_num = cmd.div_start_hold ? num_hold : num_raw;
    assign div_den = cmd.div_start_hold ? DIV_DEN_W'(unsigned'(rate_div)) : span_ba;

    bgs_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start_raw | cmd.div_start_hold),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign tens = CAP_W'((CAP_W'(idx_reg) - CAP_W'(1)) * CAP_W'(10));

    always_comb begin
        shown_next = shown_reg;
        if (shown_reg == CAP_UNMEASURED) begin
            shown_next = raw_reg;
        end else if (ac_reg) begin
            shown_next = (shown_reg >= CAP_FULL) ? CAP_FULL : shown_reg + CAP_W'(1);
        end else if (raw_reg >= CAP_FULL) begin
            shown_next = shown_reg;
        end else begin
            shown_next = (shown_reg == CAP_EMPTY) ? CAP_EMPTY : shown_reg - CAP_W'(1);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.dec_count) begin
            count_next = count_reg - COUNT_W'(1);
        end else if (cmd.count_from_div) begin
            // A zero quotient falls back to the charging period in either mode.
            count_next = (div_q == '0) ? COUNT_W'(chg_hold_reg) : div_q[COUNT_W-1:0];
        end
    end

    always_comb begin
        if (ac_reg) begin
            status_now = full_reg ? STATUS_FULL : STATUS_CHARGING;
        end else begin
            status_now = (shown_reg == CAP_FULL) ? STATUS_FULL : STATUS_NOT_CHARGING;
        end
    end
    assign changed_now = (status_now != last_status_reg) || (shown_reg != last_cap_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg       <= CAP_UNMEASURED;
            count_reg       <= '0;
            last_status_reg <= STATUS_UNKNOWN;
            last_cap_reg    <= CAP_EMPTY;
            out_valid_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.update_shown) begin
                shown_reg <= shown_next;
            end
            if (cmd.report) begin
                out_valid_reg <= 1'b1;
                if (changed_now) begin
                    last_status_reg <= status_now;
                    last_cap_reg    <= shown_reg;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sample_reg <= s_tdata[ADC_WIDTH-1:0];
            ac_reg     <= s_tdata[ADC_WIDTH];
            full_reg   <= s_tdata[ADC_WIDTH+1];
        end
        if (cmd.search_init) begin
            idx_reg <= IDX_FIRST;
        end else if (cmd.search_step) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
        if (cmd.raw_full) begin
            raw_reg <= CAP_FULL;
        end else if (cmd.raw_zero) begin
            raw_reg <= CAP_EMPTY;
        end else if (cmd.raw_from_div) begin
            raw_reg <= div_q[CAP_W-1:0] + tens;
        end
        if (cmd.report) begin
            out_data_reg <= {changed_now, status_now, shown_reg};
        end
    end

    assign stat.sample_zero = (sample_reg == '0);
    assign stat.count_zero  = (count_reg == '0);
    assign stat.full        = full_reg;
    assign stat.le_first    = (sample_ext <= CMP_W'(bp_first));
    assign stat.le_cur      = (sample_ext <= CMP_W'(bp_cur));
    assign stat.idx_last    = (idx_reg == IDX_LAST);
    assign stat.div_busy    = div_busy;
    assign stat.out_free    = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_data_reg);

    // The shown value is either a percentage or the unmeasured marker.
    assert property (@(posedge aclk) disable iff (!aresetn)
        shown_reg <= CAP_FULL || shown_reg == CAP_UNMEASURED)
        else $error("shown capacity left its legal range");

    // Interpolation only starts on a strictly increasing breakpoint pair.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start_raw |-> (span_ba != '0 && span_vb <= span_ba))
        else $error("interpolation span is empty or exceeded");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start_hold |-> (rate_div > 8'sd0))
        else $error("reload divisor is not positive");

    // An interpolated step never exceeds ten percent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.raw_from_div |-> (div_q <= DIV_NUM_W'(10)))
        else $error("interpolation step above ten percent");

endmodule

[rtl/bgs_ctrl.sv]
// Controller state machine that sequences one tick through the datapath.
module bgs_ctrl
    import bgs_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bgs_stat_t stat,
    output bgs_cmd_t  cmd
);

    bgs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (stat.sample_zero || !stat.count_zero) begin
                    state_next = ST_REPORT;
                end else if (stat.full || stat.le_first) begin
                    state_next = ST_SHOW;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (stat.le_cur) begin
                    state_next = ST_DIV_RAW;
                end else if (stat.idx_last) begin
                    state_next = ST_SHOW;
                end
            end
            ST_DIV_RAW: begin
                if (!stat.div_busy) state_next = ST_SHOW;
            end
            ST_SHOW:     state_next = ST_HOLD;
            ST_HOLD:     state_next = ST_DIV_HOLD;
            ST_DIV_HOLD: begin
                if (!stat.div_busy) state_next = ST_REPORT;
            end
            ST_REPORT: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_DECIDE: begin
                if (stat.sample_zero) begin
                    cmd = '0;
                end else if (!stat.count_zero) begin
                    cmd.dec_count = 1'b1;
                end else if (stat.full) begin
                    cmd.raw_full = 1'b1;
                end else if (stat.le_first) begin
                    cmd.raw_zero = 1'b1;
                end else begin
                    cmd.search_init = 1'b1;
                end
            end
            ST_SEARCH: begin
                if (stat.le_cur) begin
                    cmd.div_start_raw = 1'b1;
                end else if (stat.idx_last) begin
                    cmd.raw_full = 1'b1;
                end else begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_DIV_RAW:  cmd.raw_from_div   = !stat.div_busy;
            ST_SHOW:     cmd.update_shown   = 1'b1;
            ST_HOLD:     cmd.div_start_hold = 1'b1;
            ST_DIV_HOLD: cmd.count_from_div = !stat.div_busy;
            ST_REPORT:   cmd.report         = stat.out_free;
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV_RAW || state_reg == ST_DIV_HOLD) && $past(state_reg) != state_reg
        |-> stat.div_busy)
        else $error("divider idle on entry to a divide state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.report |=> state_reg == ST_IDLE)
        else $error("report did not return to idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.raw_full, cmd.raw_zero, cmd.raw_from_div}) <= 1)
        else $error("conflicting raw capacity loads");

endmodule

[rtl/battery_gauge_smoother.sv]
// Top level of the battery gauge smoother: controller plus datapath.
//
// Usage: one input beat per measurement tick on s_tvalid/s_tready/s_tdata
// carries the converter sample, the adapter-present level and the
// charge-full level. Each input beat produces exactly one result beat on
// m_tvalid/m_tready/m_tdata with the shown capacity, the supply status and
// the changed flag. Configuration is written through cfg_valid/cfg_ready
// with a register index and data; cfg_ready is always high, and writes
// should be made while the block is idle.
// Sequencing: a zero sample or a running countdown passes from the decide
// state straight to the report state. A reload tick walks the breakpoints
// from the second upward, one per cycle, until one covers the sample or the
// last is reached, runs the shared divider for the interpolation when one
// covers it, then again for the reload period. One tick is in flight at a time;
// s_tready rises again once the result is in the output register.
// Reset: aresetn (synchronous, active low) restores the default tables and
// hold periods, sets the shown capacity to unmeasured and clears the
// countdown. When the receiver stalls, the result beat holds in the output
// register; the next input beat may be accepted but its result waits.
module battery_gauge_smoother
    import bgs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] adc_sample, [10] adapter_present, [11] charge_full
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [6:0] shown_capacity, [8:7] supply_status, [9] status_changed
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    bgs_cmd_t  cmd;
    bgs_stat_t stat;

    assign cfg_ready = 1'b1;

    bgs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bgs_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[sim/battery_gauge_smoother_tb.sv]
// Self-checking testbench for the battery gauge smoother: directed ticks, then random ticks.
`timescale 1ns / 1ps

module battery_gauge_smoother_tb;
    import bgs_pkg::*;

    localparam int RUN_LIMIT   = 1000000;
    localparam int TAIL_CYCLES = 64;
    localparam int PHASE_TICKS = 100;
    localparam int PHASES      = 8;

    // Indexes past the register list; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic [CAP_W-1:0]    pct;
        logic [STATUS_W-1:0] status;
        logic                changed;
    } gauge_out_t;

    typedef struct packed {
        logic [ADC_WIDTH-1:0] sample;
        logic                 ac;
        logic                 full;
        logic                 known;
        gauge_out_t           want;
    } tick_row_t;

    typedef enum int {TBL_RESET, TBL_SORTED, TBL_ZERO, TBL_ONES, TBL_RANDOM} table_kind_t;

    // Known rows assume both hold periods are 1 and the reset tables.
    localparam tick_row_t DIRECTED [24] = '{
        '{10'd0,    1'b0, 1'b0, 1'b1, '{CAP_UNMEASURED, STATUS_NOT_CHARGING, 1'b1}},
        '{10'd0,    1'b0, 1'b0, 1'b1, '{CAP_UNMEASURED, STATUS_NOT_CHARGING, 1'b0}},
        '{10'd0,    1'b1, 1'b0, 1'b1, '{CAP_UNMEASURED, STATUS_CHARGING, 1'b1}},
        '{10'd0,    1'b1, 1'b1, 1'b1, '{CAP_UNMEASURED, STATUS_FULL, 1'b1}},
        '{10'd1023, 1'b1, 1'b1, 1'b1, '{CAP_FULL, STATUS_FULL, 1'b1}},
        '{10'd1023, 1'b1, 1'b1, 1'b1, '{CAP_FULL, STATUS_FULL, 1'b0}},
        '{10'd1023, 1'b1, 1'b1, 1'b1, '{CAP_FULL, STATUS_FULL, 1'b0}},
        '{10'd1,    1'b0, 1'b0, 1'b1, '{CAP_FULL, STATUS_FULL, 1'b0}},
        '{10'd1,    1'b0, 1'b0, 1'b0, '0},
        '{10'd1,    1'b0, 1'b0, 1'b0, '0},
        '{10'd1023, 1'b0, 1'b0, 1'b0, '0},
        '{10'd1023, 1'b0, 1'b0, 1'b0, '0},
        '{10'd400,  1'b0, 1'b1, 1'b0, '0},
        '{10'd512,  1'b1, 1'b0, 1'b0, '0},
        '{10'd512,  1'b1, 1'b0, 1'b0, '0},
        '{10'd700,  1'b0, 1'b0, 1'b0, '0},
        '{10'd700,  1'b0, 1'b0, 1'b0, '0},
        '{10'd0,    1'b0, 1'b0, 1'b0, '0},
        '{10'd300,  1'b1, 1'b0, 1'b0, '0},
        '{10'd300,  1'b1, 1'b0, 1'b0, '0},
        '{10'd1,    1'b1, 1'b0, 1'b0, '0},
        '{10'd1,    1'b1, 1'b0, 1'b0, '0},
        '{10'd1023, 1'b1, 1'b0, 1'b0, '0},
        '{10'd1023, 1'b1, 1'b0, 1'b0, '0}
    };

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [9:0] adc_sample, [10] adapter_present, [11] charge_full
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [6:0] shown_capacity, [8:7] supply_status, [9] status_changed
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int send_idle  = 0;
    int recv_idle  = 0;
    int fail_count = 0;

    gauge_out_t gauge_expect [$];

    // Shadow of the gauge registers and state.
    logic [LOW_W-1:0]    chg_low  = RST_CHARGE_LOW;
    logic [HIGH_W-1:0]   chg_high = RST_CHARGE_HIGH;
    logic [LOW_W-1:0]    dis_low  = RST_DISCHARGE_LOW;
    logic [HIGH_W-1:0]   dis_high = RST_DISCHARGE_HIGH;
    logic [HOLD_W-1:0]   chg_hold = RST_CHARGE_HOLD;
    logic [HOLD_W-1:0]   dis_hold = RST_DISCHARGE_HOLD;
    logic [CAP_W-1:0]    shown_pct      = CAP_UNMEASURED;
    logic [COUNT_W-1:0]  hold_left      = '0;
    logic [STATUS_W-1:0] reported_status = STATUS_UNKNOWN;
    logic [CAP_W-1:0]    reported_pct   = '0;

    battery_gauge_smoother u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int volt_point(input logic ac, input int idx);
        logic [TABLE_W-1:0] tbl;
        tbl = ac ? {chg_high, chg_low} : {dis_high, dis_low};
        return int'(tbl[idx*BP_W +: BP_W]);
    endfunction

    function automatic int raw_percent(input logic [ADC_WIDTH-1:0] sample, input logic ac,
                                       input logic full);
        int v;
        int lo_pt;
        int hi_pt;
        v = int'(sample);
        if (full)
            return int'(CAP_FULL);
        if (v <= volt_point(ac, 0))
            return 0;
        // The first breakpoint the sample does not exceed closes the segment.
        for (int i = 1; i < BREAKPOINTS; i++) begin
            hi_pt = volt_point(ac, i);
            if (v <= hi_pt) begin
                lo_pt = volt_point(ac, i - 1);
                return (v - lo_pt) * 10 / (hi_pt - lo_pt) + 10 * (i - 1);
            end
        end
        return int'(CAP_FULL);
    endfunction

    function automatic gauge_out_t gauge_tick(input logic [ADC_WIDTH-1:0] sample, input logic ac,
                                              input logic full);
        gauge_out_t res;
        int raw;
        int diff;
        int quotient;
        if (sample != '0) begin
            if (hold_left == '0) begin
                raw = raw_percent(sample, ac, full);
                if (shown_pct == CAP_UNMEASURED)
                    shown_pct = CAP_W'(raw);
                else if (ac)
                    shown_pct = (shown_pct >= CAP_FULL) ? CAP_FULL : shown_pct + 1'b1;
                else if (raw < int'(CAP_FULL) && shown_pct != CAP_EMPTY)
                    shown_pct = shown_pct - 1'b1;

                diff = raw - int'(shown_pct);
                if (ac) begin
                    if (diff < -int'(DIFF_LIMIT))
                        diff = -int'(DIFF_LIMIT);
                    quotient = int'(chg_hold) * int'(RATE_BASE) / (int'(RATE_BASE) + diff);
                end else begin
                    if (diff > int'(DIFF_LIMIT))
                        diff = int'(DIFF_LIMIT);
                    quotient = int'(dis_hold) * int'(RATE_BASE) / (int'(RATE_BASE) - diff);
                end
                // A zero period falls back to the charging period, on battery as well.
                if (quotient == 0)
                    quotient = int'(chg_hold);
                hold_left = COUNT_W'(quotient);
            end else begin
                hold_left = hold_left - 1'b1;
            end
        end

        if (ac)
            res.status = full ? STATUS_FULL : STATUS_CHARGING;
        else
            res.status = (shown_pct == CAP_FULL) ? STATUS_FULL : STATUS_NOT_CHARGING;
        res.pct = shown_pct;
        res.changed = (res.status != reported_status) || (shown_pct != reported_pct);
        if (res.changed) begin
            reported_status = res.status;
            reported_pct = shown_pct;
        end
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CHARGE_LOW:     chg_low  = data[LOW_W-1:0];
            CFG_CHARGE_HIGH:    chg_high = data[HIGH_W-1:0];
            CFG_DISCHARGE_LOW:  dis_low  = data[LOW_W-1:0];
            CFG_DISCHARGE_HIGH: dis_high = data[HIGH_W-1:0];
            CFG_CHARGE_HOLD:    chg_hold = data[HOLD_W-1:0];
            CFG_DISCHARGE_HOLD: dis_hold = data[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic make_table(input table_kind_t kind, input logic for_charge,
                              output logic [TABLE_W-1:0] tbl);
        int unsigned pts [$];
        tbl = '0;
        case (kind)
            TBL_RESET:
                tbl = for_charge ? {RST_CHARGE_HIGH, RST_CHARGE_LOW}
                                 : {RST_DISCHARGE_HIGH, RST_DISCHARGE_LOW};
            TBL_ZERO: tbl = '0;
            TBL_ONES: tbl = '1;
            TBL_RANDOM: tbl = TABLE_W'({$urandom, $urandom, $urandom, $urandom});
            default: begin
                for (int i = 0; i < BREAKPOINTS; i++)
                    pts.push_back($urandom_range(0, 1023));
                pts.sort();
                for (int i = 0; i < BREAKPOINTS; i++)
                    tbl[i*BP_W +: BP_W] = BP_W'(pts[i]);
            end
        endcase
    endtask

    // Writes every register; spare upper data bits are random to exercise masking.
    task automatic configure_phase(input int phase);
        table_kind_t        kind;
        int                 hold_c;
        int                 hold_d;
        logic [TABLE_W-1:0] ct;
        logic [TABLE_W-1:0] dt;
        case (phase)
            0: begin kind = TBL_SORTED; hold_c = $urandom_range(1, 4); hold_d = $urandom_range(1, 4); end
            1: begin kind = TBL_ZERO;   hold_c = 1; hold_d = 1; end
            2: begin kind = TBL_ONES;   hold_c = 1; hold_d = 3; end
            3: begin kind = TBL_RANDOM; hold_c = $urandom_range(1, 8); hold_d = $urandom_range(1, 8); end
            4: begin kind = TBL_RESET;  hold_c = 255; hold_d = 255; end
            5: begin kind = TBL_SORTED; hold_c = $urandom_range(1, 20); hold_d = $urandom_range(1, 20); end
            6: begin kind = TBL_SORTED; hold_c = $urandom_range(1, 4); hold_d = $urandom_range(1, 4); end
            default: begin
                kind = TBL_RESET;
                hold_c = int'(RST_CHARGE_HOLD);
                hold_d = int'(RST_DISCHARGE_HOLD);
            end
        endcase
        make_table(kind, 1'b1, ct);
        make_table(kind, 1'b0, dt);
        write_reg(CFG_RESERVED_LO, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(CFG_CHARGE_LOW, ct[LOW_W-1:0]);
        write_reg(CFG_CHARGE_HIGH, {10'($urandom), ct[TABLE_W-1:LOW_W]});
        write_reg(CFG_DISCHARGE_LOW, dt[LOW_W-1:0]);
        write_reg(CFG_DISCHARGE_HIGH, {10'($urandom), dt[TABLE_W-1:LOW_W]});
        write_reg(CFG_CHARGE_HOLD, {52'({$urandom, $urandom}), 8'(hold_c)});
        write_reg(CFG_DISCHARGE_HOLD, {52'({$urandom, $urandom}), 8'(hold_d)});
        write_reg(CFG_RESERVED_HI, CFG_DATA_W'({$urandom, $urandom}));
        cfg_valid <= 1'b0;
    endtask

    task automatic push_tick(input logic [ADC_WIDTH-1:0] sample, input logic ac, input logic full,
                             input logic known, input gauge_out_t typed);
        gauge_out_t predicted;
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({full, ac, sample});
        do @(posedge aclk); while (!s_tready);
        predicted = gauge_tick(sample, ac, full);
        gauge_expect.push_back(known ? typed : predicted);
    endtask

    // Adapter sessions of random length with a drifting voltage, plus noise.
    task automatic run_random(input int count);
        int                   level;
        int                   run_left;
        int                   pick;
        logic                 ac;
        logic                 full;
        logic [ADC_WIDTH-1:0] sample;
        level = $urandom_range(1, 1023);
        run_left = 0;
        ac = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (run_left == 0) begin
                ac = 1'($urandom_range(0, 1));
                run_left = $urandom_range(1, 40);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                sample = '0;
            end else if (pick < 18) begin
                sample = ADC_WIDTH'($urandom_range(0, 1023));
            end else begin
                level = level + $urandom_range(0, 40) - 20;
                if (level < 1)
                    level = 1;
                if (level > 1023)
                    level = 1023;
                sample = ADC_WIDTH'(level);
            end
            full = ($urandom_range(0, 99) < (ac ? 15 : 5));
            push_tick(sample, ac, full, 1'b0, '0);
        end
    endtask

    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (gauge_expect.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        gauge_out_t want;
        gauge_out_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.pct     = m_tdata[CAP_W-1:0];
            got.status  = m_tdata[CAP_W +: STATUS_W];
            got.changed = m_tdata[CAP_W + STATUS_W];
            if (gauge_expect.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat: cap %0d status %0d changed %0d",
                             got.pct, got.status, got.changed);
            end else begin
                want = gauge_expect.pop_front();
                if (got.pct !== want.pct || got.status !== want.status
                        || got.changed !== want.changed) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: expected cap %0d status %0d changed %0d, ",
                                  "got cap %0d status %0d changed %0d"},
                                 want.pct, want.status, want.changed,
                                 got.pct, got.status, got.changed);
                end
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle = 25;
        recv_idle = 78;
        write_reg(CFG_CHARGE_HOLD, CFG_DATA_W'(1));
        write_reg(CFG_DISCHARGE_HOLD, CFG_DATA_W'(1));
        cfg_valid <= 1'b0;
        foreach (DIRECTED[i])
            push_tick(DIRECTED[i].sample, DIRECTED[i].ac, DIRECTED[i].full,
                      DIRECTED[i].known, DIRECTED[i].want);

        for (int p = 0; p < PHASES; p++) begin
            // Registers change only once every outstanding result has come back.
            drain_results();
            if (p == 3) begin
                send_idle = 78;
                recv_idle = 25;
            end else if (p == 6) begin
                send_idle = 0;
                recv_idle = 0;
            end
            configure_phase(p);
            run_random(PHASE_TICKS);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        fail_count += gauge_expect.size();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/bgs_pkg.sv
rtl/bgs_divider.sv
rtl/bgs_datapath.sv
rtl/bgs_ctrl.sv
rtl/battery_gauge_smoother.sv
sim/battery_gauge_smoother_tb.sv
